/* src/assert_macros.svh */
// Assertion helpers used by the bound checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define A_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, quiet while reset is asserted.
`define A_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that is also checked through reset.
`define A_NEXT_ALL(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset-time check failed");

`endif

/* src/tbrd_pkg.sv */
package tbrd_pkg;

    localparam int NUM_ENTRIES_DEF = 1024;

    localparam int IDX_W   = 10;
    localparam int LVL_W   = 16;
    localparam int TIME_W  = 32;
    localparam int PROD_W  = TIME_W + LVL_W;
    localparam int SUM_W   = 26;
    localparam int TOTAL_W = 30;

    localparam logic [TOTAL_W-1:0] MODULUS = 30'd1000000007;

    typedef struct packed {
        logic [LVL_W-1:0]  level;
        logic [LVL_W-1:0]  cap;
        logic [LVL_W-1:0]  rate;
        logic [TIME_W-1:0] last;
    } entry_t;

endpackage

/* src/tbrd_refill.sv */
module tbrd_refill (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        in_valid,
    input  tbrd_pkg::entry_t            in_entry,
    input  logic [tbrd_pkg::TIME_W-1:0] now_time,
    output logic                        out_valid,
    output logic [tbrd_pkg::LVL_W-1:0]  out_level,
    output logic                        busy
);

    logic                          v1_reg, v2_reg, v3_reg;
    logic [tbrd_pkg::TIME_W-1:0]   elapsed_reg;
    logic [tbrd_pkg::LVL_W-1:0]    lvl1_reg, cap1_reg, rate1_reg;
    logic [tbrd_pkg::PROD_W-1:0]   prod_reg;
    logic [tbrd_pkg::LVL_W-1:0]    lvl2_reg, cap2_reg;
    logic [tbrd_pkg::LVL_W-1:0]    grown_reg;

    logic [tbrd_pkg::TIME_W-1:0]   elapsed_next;
    logic [tbrd_pkg::PROD_W-1:0]   prod_next;
    logic [tbrd_pkg::PROD_W:0]     sum_wide;
    logic [tbrd_pkg::LVL_W-1:0]    grown_next;

    always_comb begin
        // time going backwards counts as no elapsed time
        elapsed_next = (now_time > in_entry.last) ? (now_time - in_entry.last)
                                                  : '0;
        prod_next    = tbrd_pkg::PROD_W'(elapsed_reg) * tbrd_pkg::PROD_W'(rate1_reg);
        sum_wide     = (tbrd_pkg::PROD_W + 1)'(lvl2_reg) + (tbrd_pkg::PROD_W + 1)'(prod_reg);
        grown_next   = (sum_wide > (tbrd_pkg::PROD_W + 1)'(cap2_reg)) ? cap2_reg
                                                                      : sum_wide[15:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
        elapsed_reg <= elapsed_next;
        lvl1_reg    <= in_entry.level;
        cap1_reg    <= in_entry.cap;
        rate1_reg   <= in_entry.rate;
        prod_reg    <= prod_next;
        lvl2_reg    <= lvl1_reg;
        cap2_reg    <= cap1_reg;
        grown_reg   <= grown_next;
    end

    assign out_valid = v3_reg;
    assign out_level = grown_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

/* src/token_bucket_range_drain_core.sv */
// Load requests give no result.
// Drain requests walk the range one entry per cycle through the bucket memory
// port, then a three-stage refill pipe, into the result register; the result
// waits while an unread result is held, and the next request is taken once
// the block is back in idle. An empty range skips the walk and the refill pipe.
// Reset (aresetn low, synchronous) clears control and the running total only.
module token_bucket_range_drain_core #(
    parameter int NUM_ENTRIES = tbrd_pkg::NUM_ENTRIES_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_action,
    input  logic [tbrd_pkg::IDX_W-1:0]   s_entry_index,
    input  logic [tbrd_pkg::LVL_W-1:0]   s_start_level,
    input  logic [tbrd_pkg::LVL_W-1:0]   s_capacity,
    input  logic [tbrd_pkg::LVL_W-1:0]   s_refill_rate,
    input  logic [tbrd_pkg::TIME_W-1:0]  s_now_time,
    input  logic [tbrd_pkg::IDX_W-1:0]   s_range_low,
    input  logic [tbrd_pkg::IDX_W-1:0]   s_range_high,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tbrd_pkg::SUM_W-1:0]   m_drained_sum,
    output logic [tbrd_pkg::TOTAL_W-1:0] m_running_total
);

    localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam logic [31:0] LAST_IDX = 32'(NUM_ENTRIES - 1);
    localparam int LT_W = tbrd_pkg::LVL_W + tbrd_pkg::TIME_W;
    localparam int CR_W = 2 * tbrd_pkg::LVL_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // level and last-touch change on every drain; capacity and rate only on load
    logic [LT_W-1:0] mem_lt [NUM_ENTRIES];
    logic [CR_W-1:0] mem_cr [NUM_ENTRIES];

    logic [1:0]                    state_reg, state_next;
    logic [AW-1:0]                 addr_reg, addr_next;
    logic [AW-1:0]                 hi_reg, hi_next;
    logic [tbrd_pkg::TIME_W-1:0]   now_reg, now_next;
    logic [tbrd_pkg::SUM_W-1:0]    acc_reg, acc_next;
    logic [tbrd_pkg::TOTAL_W-1:0]  grand_reg, grand_next;
    logic                          rd_valid_reg;
    logic [LT_W-1:0]               rd_lt_reg;
    logic [CR_W-1:0]               rd_cr_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [tbrd_pkg::SUM_W-1:0]    m_sum_reg, m_sum_next;
    logic [tbrd_pkg::TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic                          accept;
    logic                          load_ok;
    logic                          walking;
    logic [31:0]                   hi_eff;
    logic                          range_empty;
    logic [tbrd_pkg::TOTAL_W:0]    gsum;
    logic [tbrd_pkg::TOTAL_W-1:0]  gsum_mod;

    tbrd_pkg::entry_t              rd_entry;
    logic                          rf_valid;
    logic [tbrd_pkg::LVL_W-1:0]    rf_level;
    logic                          rf_busy;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;
    assign load_ok = accept & !s_action & (32'(s_entry_index) < 32'(NUM_ENTRIES));
    assign walking = (state_reg == ST_WALK);

    assign hi_eff      = (32'(s_range_high) > LAST_IDX) ? LAST_IDX : 32'(s_range_high);
    assign range_empty = 32'(s_range_low) > hi_eff;

    // read-first: the walk reads the old word and stamps it empty in the same cycle
    always_ff @(posedge aclk) begin
        if (load_ok) begin
            mem_lt[AW'(s_entry_index)] <= {s_start_level, {tbrd_pkg::TIME_W{1'b0}}};
            mem_cr[AW'(s_entry_index)] <= {s_capacity, s_refill_rate};
        end else if (walking) begin
            mem_lt[addr_reg] <= {{tbrd_pkg::LVL_W{1'b0}}, now_reg};
        end
        if (walking) begin
            rd_lt_reg <= mem_lt[addr_reg];
            rd_cr_reg <= mem_cr[addr_reg];
        end
    end

    assign rd_entry.level = rd_lt_reg[LT_W-1:tbrd_pkg::TIME_W];
    assign rd_entry.last  = rd_lt_reg[tbrd_pkg::TIME_W-1:0];
    assign rd_entry.cap   = rd_cr_reg[CR_W-1:tbrd_pkg::LVL_W];
    assign rd_entry.rate  = rd_cr_reg[tbrd_pkg::LVL_W-1:0];

    tbrd_refill u_refill (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rd_valid_reg),
        .in_entry  (rd_entry),
        .now_time  (now_reg),
        .out_valid (rf_valid),
        .out_level (rf_level),
        .busy      (rf_busy)
    );

    always_comb begin
        gsum     = (tbrd_pkg::TOTAL_W + 1)'(grand_reg) + (tbrd_pkg::TOTAL_W + 1)'(acc_reg);
        gsum_mod = (gsum >= (tbrd_pkg::TOTAL_W + 1)'(tbrd_pkg::MODULUS))
                 ? tbrd_pkg::TOTAL_W'(gsum - (tbrd_pkg::TOTAL_W + 1)'(tbrd_pkg::MODULUS))
                 : tbrd_pkg::TOTAL_W'(gsum);
    end

    always_comb begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        hi_next      = hi_reg;
        now_next     = now_reg;
        acc_next     = acc_reg;
        grand_next   = grand_reg;
        m_valid_next = m_valid_reg & !m_ready;
        m_sum_next   = m_sum_reg;
        m_total_next = m_total_reg;

        if (rf_valid) begin
            acc_next = acc_reg + tbrd_pkg::SUM_W'(rf_level);
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept && s_action) begin
                    acc_next  = '0;
                    now_next  = s_now_time;
                    addr_next = AW'(s_range_low);
                    hi_next   = AW'(hi_eff);
                    state_next = range_empty ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                addr_next = addr_reg + AW'(1);
                if (addr_reg == hi_reg) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (!rd_valid_reg && !rf_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next   = acc_reg;
                    m_total_next = gsum_mod;
                    grand_next   = gsum_mod;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            grand_reg    <= '0;
            rd_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            grand_reg    <= grand_next;
            rd_valid_reg <= walking;
            m_valid_reg  <= m_valid_next;
        end
        addr_reg    <= addr_next;
        hi_reg      <= hi_next;
        now_reg     <= now_next;
        acc_reg     <= acc_next;
        m_sum_reg   <= m_sum_next;
        m_total_reg <= m_total_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_drained_sum   = m_sum_reg;
    assign m_running_total = m_total_reg;

endmodule

/* src/tbrd_checker.sv */
`include "assert_macros.svh"

module tbrd_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         s_action,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [tbrd_pkg::SUM_W-1:0]   m_drained_sum,
    input logic [tbrd_pkg::TOTAL_W-1:0] m_running_total
);

    `A_NEXT_ALL(a_reset_no_result, aclk, !aresetn, !m_valid)

    `A_NEXT(a_load_gives_nothing, aclk, aresetn, s_valid && s_ready && !s_action && !m_valid, !m_valid)

    `A_NEXT(a_drain_blocks_input, aclk, aresetn, s_valid && s_ready && s_action, !s_ready)

    `A_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_drained_sum) && $stable(m_running_total))

    `A_IMPL(a_total_reduced, aclk, aresetn, m_valid, m_running_total < tbrd_pkg::MODULUS)

endmodule

bind token_bucket_range_drain_core tbrd_checker u_tbrd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_action        (s_action),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_drained_sum   (m_drained_sum),
    .m_running_total (m_running_total)
);

/* tb/sv/token_bucket_drain_checker.sv */
module token_bucket_drain_checker
    import tbrd_pkg::*;
#(
    parameter int   NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter logic DRAIN_CODE  = 1'b1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_action,
    input  logic [IDX_W-1:0]   s_entry_index,
    input  logic [LVL_W-1:0]   s_start_level,
    input  logic [LVL_W-1:0]   s_capacity,
    input  logic [LVL_W-1:0]   s_refill_rate,
    input  logic [TIME_W-1:0]  s_now_time,
    input  logic [IDX_W-1:0]   s_range_low,
    input  logic [IDX_W-1:0]   s_range_high,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [SUM_W-1:0]   m_drained_sum,
    input  logic [TOTAL_W-1:0] m_running_total,
    output int                 fail_count,
    output int                 open_drains
);

    localparam logic [63:0] SUM_SAT = 64'((1 << SUM_W) - 1);

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [TOTAL_W-1:0] total;
    } drain_result_t;

    entry_t             bucket_bank [NUM_ENTRIES];
    logic [TOTAL_W-1:0] total_mod;
    drain_result_t      drain_results_q [$];
    int                 mismatches = 0;

    function automatic logic [63:0] refilled_level(entry_t e, logic [TIME_W-1:0] now);
        logic [63:0] elapsed;
        logic [63:0] grown;
        // time going backwards adds nothing
        elapsed = (now > e.last) ? 64'(now - e.last) : 64'd0;
        grown   = 64'(e.level) + elapsed * 64'(e.rate);
        return (grown > 64'(e.cap)) ? 64'(e.cap) : grown;
    endfunction

    function automatic drain_result_t drain_range(logic [TIME_W-1:0] now, int lo, int hi);
        logic [63:0]   acc;
        drain_result_t res;
        int            i;
        acc = 64'd0;
        if (hi > NUM_ENTRIES - 1) begin
            hi = NUM_ENTRIES - 1;
        end
        for (i = lo; i <= hi; i++) begin
            acc += refilled_level(bucket_bank[i], now);
            bucket_bank[i].level = '0;
            bucket_bank[i].last  = now;
        end
        // the running total takes the exact sum, the result field saturates
        total_mod = TOTAL_W'((64'(total_mod) + acc % 64'(MODULUS)) % 64'(MODULUS));
        res.sum   = SUM_W'((acc > SUM_SAT) ? SUM_SAT : acc);
        res.total = total_mod;
        return res;
    endfunction

    always @(posedge aclk) begin
        drain_result_t want;
        if (!aresetn) begin
            total_mod = '0;
            drain_results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (drain_results_q.size() == 0) begin
                    $error("result with no drain request pending: drained_sum %0d, running_total %0d",
                           m_drained_sum, m_running_total);
                    mismatches++;
                end else begin
                    want = drain_results_q.pop_front();
                    if (m_drained_sum !== want.sum) begin
                        $error("drained_sum mismatch: expected %0d, actual %0d",
                               want.sum, m_drained_sum);
                        mismatches++;
                    end
                    if (m_running_total !== want.total) begin
                        $error("running_total mismatch: expected %0d, actual %0d",
                               want.total, m_running_total);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_action == DRAIN_CODE) begin
                    drain_results_q.push_back(drain_range(s_now_time, int'(s_range_low),
                                                          int'(s_range_high)));
                end else if (int'(s_entry_index) < NUM_ENTRIES) begin
                    bucket_bank[s_entry_index].level = s_start_level;
                    bucket_bank[s_entry_index].cap   = s_capacity;
                    bucket_bank[s_entry_index].rate  = s_refill_rate;
                    bucket_bank[s_entry_index].last  = '0;
                end
            end
        end
        fail_count  <= mismatches;
        open_drains <= drain_results_q.size();
    end

endmodule

/* tb/sv/tb_token_bucket_range_drain_core.sv */
module tb_token_bucket_range_drain_core;
    import tbrd_pkg::*;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_DRAIN = 1'b1;
    localparam int   N_ENTRIES = NUM_ENTRIES_DEF;
    localparam int   CYCLE_LIMIT = 1_000_000;
    localparam int   TAIL_CYCLES = 16;
    // large enough that any nonzero rate refills an entry to its capacity
    localparam logic [TIME_W-1:0] BIG_STEP = 32'h0400_0000;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_action = ACT_LOAD;
    logic [IDX_W-1:0]   s_entry_index = '0;
    logic [LVL_W-1:0]   s_start_level = '0;
    logic [LVL_W-1:0]   s_capacity = '0;
    logic [LVL_W-1:0]   s_refill_rate = '0;
    logic [TIME_W-1:0]  s_now_time = '0;
    logic [IDX_W-1:0]   s_range_low = '0;
    logic [IDX_W-1:0]   s_range_high = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [SUM_W-1:0]   m_drained_sum;
    logic [TOTAL_W-1:0] m_running_total;

    int                 fail_count;
    int                 open_drains;
    int                 cycle_count = 0;
    int                 burst_left = 0;
    logic [TIME_W-1:0]  clock_now = '0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    token_bucket_range_drain_core #(
        .NUM_ENTRIES(N_ENTRIES)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_entry_index  (s_entry_index),
        .s_start_level  (s_start_level),
        .s_capacity     (s_capacity),
        .s_refill_rate  (s_refill_rate),
        .s_now_time     (s_now_time),
        .s_range_low    (s_range_low),
        .s_range_high   (s_range_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drained_sum  (m_drained_sum),
        .m_running_total(m_running_total)
    );

    token_bucket_drain_checker #(
        .NUM_ENTRIES(N_ENTRIES),
        .DRAIN_CODE (ACT_DRAIN)
    ) drain_chk (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_entry_index  (s_entry_index),
        .s_start_level  (s_start_level),
        .s_capacity     (s_capacity),
        .s_refill_rate  (s_refill_rate),
        .s_now_time     (s_now_time),
        .s_range_low    (s_range_low),
        .s_range_high   (s_range_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_drained_sum  (m_drained_sum),
        .m_running_total(m_running_total),
        .fail_count     (fail_count),
        .open_drains    (open_drains)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic send_request(input logic act, input logic [IDX_W-1:0] idx,
                                input logic [LVL_W-1:0] lvl, input logic [LVL_W-1:0] cap,
                                input logic [LVL_W-1:0] rate, input logic [TIME_W-1:0] now,
                                input logic [IDX_W-1:0] lo, input logic [IDX_W-1:0] hi);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            // mostly short bursts, now and then a long unbroken stretch
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_entry_index <= idx;
        s_start_level <= lvl;
        s_capacity    <= cap;
        s_refill_rate <= rate;
        s_now_time    <= now;
        s_range_low   <= lo;
        s_range_high  <= hi;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
    endtask

    // fields a request does not use carry random noise
    task automatic load_entry(input int idx, input logic [LVL_W-1:0] lvl,
                              input logic [LVL_W-1:0] cap, input logic [LVL_W-1:0] rate);
        send_request(ACT_LOAD, IDX_W'(idx), lvl, cap, rate, $urandom(),
                     IDX_W'($urandom()), IDX_W'($urandom()));
    endtask

    task automatic drain(input logic [TIME_W-1:0] now, input int lo, input int hi);
        send_request(ACT_DRAIN, IDX_W'($urandom()), LVL_W'($urandom()), LVL_W'($urandom()),
                     LVL_W'($urandom()), now, IDX_W'(lo), IDX_W'(hi));
    endtask

    function automatic logic [LVL_W-1:0] pick_level();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            2: return LVL_W'($urandom_range(0, 15));
            default: return LVL_W'($urandom());
        endcase
    endfunction

    function automatic logic [TIME_W-1:0] advance_time();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            clock_now = clock_now - TIME_W'($urandom_range(1, 50));
        end else if (pick < 8) begin
            clock_now = $urandom();
        end else begin
            clock_now = clock_now + TIME_W'($urandom_range(0, 20));
        end
        return clock_now;
    endfunction

    initial begin
        int i;
        int pick;
        int lo;
        int len;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        load_entry(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        load_entry(1, 16'd100, 16'd50, 16'd0);        // level above capacity
        load_entry(2, 16'd0, 16'd0, 16'd0);
        load_entry(N_ENTRIES - 2, 16'd0, 16'hFFFF, 16'd1);
        load_entry(N_ENTRIES - 1, 16'd1234, 16'd40000, 16'd7);
        drain(32'd0, 0, 2);
        drain(32'd10, 0, 2);
        drain(32'd4, 0, 1);                            // time went backwards
        drain(32'hFFFF_FFFF, N_ENTRIES - 2, N_ENTRIES - 1);
        drain(32'd100, N_ENTRIES - 1, N_ENTRIES - 1);
        drain(32'd7, N_ENTRIES - 1, 0);                // empty range
        drain(32'd5, 2, 1);
        load_entry(1, 16'd0, 16'hFFFF, 16'hFFFF);
        drain(32'd3, 1, 1);
        load_entry(2, 16'hFFFF, 16'hFFFF, 16'd0);
        drain(32'd0, 2, 2);

        // fill the bank full, then drain it whole until the running total wraps
        for (i = 0; i < N_ENTRIES; i++) begin
            load_entry(i, 16'hFFFF, 16'hFFFF, LVL_W'($urandom_range(1, 65535)));
        end
        for (i = 1; i <= 17; i++) begin
            drain(BIG_STEP * i, 0, N_ENTRIES - 1);
        end
        clock_now = BIG_STEP * 17;

        repeat (1000) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                load_entry($urandom_range(0, N_ENTRIES - 1), pick_level(), pick_level(),
                           pick_level());
            end else if (pick < 45) begin
                lo = $urandom_range(1, N_ENTRIES - 1);
                drain(advance_time(), lo, $urandom_range(0, lo - 1));
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 70) begin
                    len = $urandom_range(1, 16);
                end else if (pick < 95) begin
                    len = $urandom_range(17, 128);
                end else begin
                    len = $urandom_range(1, N_ENTRIES);
                end
                lo = $urandom_range(0, N_ENTRIES - len);
                drain(advance_time(), lo, lo + len - 1);
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        wait (open_drains == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && open_drains == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // receiver: rotating stall modes, plus two long hold-offs to back up the block
    initial begin
        int mode;
        int mode_left;
        int taken;
        int hold_left;
        int holds_done;
        int cyc;
        mode = 0;
        mode_left = 0;
        taken = 0;
        hold_left = 0;
        holds_done = 0;
        cyc = 0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            cyc++;
            if (m_valid && m_ready) begin
                taken++;
            end
            if (hold_left == 0 && ((holds_done == 0 && taken >= 5) ||
                                   (holds_done == 1 && taken >= 250))) begin
                hold_left = 2500;
                holds_done++;
            end
            if (mode_left == 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 400);
            end
            mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= (cyc % 3 != 0);
                endcase
            end
        end
    end

endmodule
